// ===== hdl/mcpp_pkg.sv =====
`default_nettype none
package mcpp_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int DEF_CHANNELS = 8;
  localparam int SAMPLE_W     = 16;
  localparam int QUEUE_DEPTH  = 2;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_MASK   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MODE   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE  = 2'd3;

  localparam logic [1:0] MODE_RECORD = 2'd0;
  localparam logic [1:0] MODE_RESET  = 2'd1;
  localparam logic [1:0] MODE_HOLD   = 2'd2;
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  localparam logic [7:0]  RST_MASK   = 8'd255;
  localparam logic [15:0] RST_LENGTH = 16'd1024;
  localparam logic [1:0]  RST_MODE   = MODE_RESET;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_0;
    logic [SAMPLE_W-1:0] sample_1;
    logic [SAMPLE_W-1:0] sample_2;
    logic [SAMPLE_W-1:0] sample_3;
    logic [SAMPLE_W-1:0] sample_4;
    logic [SAMPLE_W-1:0] sample_5;
    logic [SAMPLE_W-1:0] sample_6;
    logic [SAMPLE_W-1:0] sample_7;
    logic                batch_end;
  } in_word_t;

  typedef struct packed {
    logic                buffer_select;
    logic [15:0]         write_address;
    logic [SAMPLE_W-1:0] sample_value;
    logic                buffer_full;
    logic                last;
  } out_word_t;

  typedef struct packed {
    logic                                   batch_end;
    logic [MAX_CHANNELS-1:0]                enables;
    logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0]  value;
  } frame_t;

  typedef struct packed {
    logic [7:0]  mask;
    logic [15:0] length;
    logic [1:0]  mode;
  } cfg_t;

  function automatic logic [SAMPLE_W-1:0] swap16(input logic [SAMPLE_W-1:0] v);
    return {v[7:0], v[15:8]};
  endfunction

endpackage
`default_nettype wire

// ===== hdl/mcpp_fifo.sv =====
`default_nettype none
module mcpp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mcpp_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = count == CW'(DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/mcpp_front.sv =====
`default_nettype none
module mcpp_front #(
  parameter int CHANNELS = mcpp_pkg::DEF_CHANNELS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire mcpp_pkg::in_word_t in_word,
  output logic                    full,
  input  wire logic [7:0]         mask,
  input  wire logic               frame_pop,
  output mcpp_pkg::frame_t        frame,
  output logic                    frame_empty
);

  localparam logic [mcpp_pkg::MAX_CHANNELS-1:0] CH_EN =
    mcpp_pkg::MAX_CHANNELS'((9'd1 << CHANNELS) - 9'd1);

  mcpp_pkg::frame_t                    entry;
  logic [$bits(mcpp_pkg::frame_t)-1:0] rd_bits;

  // byte swap and channel enables, ahead of the queue
  always_comb begin
    entry.batch_end = in_word.batch_end;
    entry.enables   = mask & CH_EN;
    entry.value[0]  = mcpp_pkg::swap16(in_word.sample_0);
    entry.value[1]  = mcpp_pkg::swap16(in_word.sample_1);
    entry.value[2]  = mcpp_pkg::swap16(in_word.sample_2);
    entry.value[3]  = mcpp_pkg::swap16(in_word.sample_3);
    entry.value[4]  = mcpp_pkg::swap16(in_word.sample_4);
    entry.value[5]  = mcpp_pkg::swap16(in_word.sample_5);
    entry.value[6]  = mcpp_pkg::swap16(in_word.sample_6);
    entry.value[7]  = mcpp_pkg::swap16(in_word.sample_7);
  end

  mcpp_fifo #(
    .WIDTH($bits(mcpp_pkg::frame_t)),
    .DEPTH(mcpp_pkg::QUEUE_DEPTH)
  ) u_frame_q (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_data(entry),
    .full   (full),
    .pop    (frame_pop),
    .rd_data(rd_bits),
    .empty  (frame_empty)
  );

  assign frame = rd_bits;

endmodule
`default_nettype wire

// ===== hdl/mcpp_back.sv =====
`default_nettype none
module mcpp_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mcpp_pkg::cfg_t   cfg,
  input  wire mcpp_pkg::frame_t frame,
  input  wire logic             frame_empty,
  output logic                  frame_pop,
  output logic                  empty,
  input  wire logic             pop,
  output mcpp_pkg::out_word_t   out_word
);

  localparam int NCH = mcpp_pkg::MAX_CHANNELS;

  logic [15:0]   write_index;
  logic [15:0]   write_index_next;
  logic          active_buffer;
  logic          active_buffer_next;
  logic          skipping_batch;
  logic          skipping_batch_next;
  logic          busy;
  logic          busy_next;
  logic [NCH-1:0] pend;
  logic [NCH-1:0] pend_next;

  logic [NCH-1:0]               cur;
  logic [NCH-1:0]               lowbit;
  logic [NCH-1:0]               rest;
  logic [mcpp_pkg::SAMPLE_W-1:0] sel_value;
  logic [15:0]                  len_m1;
  logic                         in_range;
  logic                         fill;
  logic                         emit;
  logic                         out_full;
  mcpp_pkg::out_word_t          emit_word;
  logic [$bits(mcpp_pkg::out_word_t)-1:0] rd_bits;

  always_comb begin
    cur       = busy ? pend : frame.enables;
    lowbit    = cur & (~cur + NCH'(1));
    rest      = cur & ~lowbit;
    sel_value = '0;
    for (int i = 0; i < NCH; i++) begin
      sel_value = sel_value | ({mcpp_pkg::SAMPLE_W{lowbit[i]}} & frame.value[i]);
    end
    len_m1   = cfg.length - 16'd1;
    in_range = (cfg.length != 16'd0) && (write_index <= len_m1);
    fill     = write_index == len_m1;

    emit_word.buffer_select = active_buffer;
    emit_word.write_address = write_index;
    emit_word.sample_value  = sel_value;
    emit_word.buffer_full   = fill;
    emit_word.last          = fill || (rest == '0);
  end

  always_comb begin
    frame_pop           = 1'b0;
    emit                = 1'b0;
    write_index_next    = write_index;
    active_buffer_next  = active_buffer;
    skipping_batch_next = skipping_batch;
    busy_next           = busy;
    pend_next           = pend;
    if (!frame_empty) begin
      unique case (cfg.mode)
        mcpp_pkg::MODE_HOLD: begin
          frame_pop = 1'b1;
          if (frame.batch_end) begin
            skipping_batch_next = 1'b0;
          end
        end
        mcpp_pkg::MODE_RECORD: begin
          if (skipping_batch) begin
            frame_pop = 1'b1;
            if (frame.batch_end) begin
              skipping_batch_next = 1'b0;
            end
          end else if ((cur == '0) || !in_range) begin
            frame_pop = 1'b1;
            busy_next = 1'b0;
          end else if (!out_full) begin
            emit = 1'b1;
            if (fill) begin
              frame_pop           = 1'b1;
              busy_next           = 1'b0;
              write_index_next    = '0;
              active_buffer_next  = ~active_buffer;
              skipping_batch_next = ~frame.batch_end;
            end else begin
              write_index_next = write_index + 16'd1;
              if (rest == '0) begin
                frame_pop = 1'b1;
                busy_next = 1'b0;
              end else begin
                busy_next = 1'b1;
                pend_next = rest;
              end
            end
          end
        end
        default: begin
          // reset mode, and the unused code
          frame_pop           = 1'b1;
          busy_next           = 1'b0;
          write_index_next    = '0;
          active_buffer_next  = 1'b0;
          skipping_batch_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index    <= '0;
      active_buffer  <= 1'b0;
      skipping_batch <= 1'b0;
      busy           <= 1'b0;
      pend           <= '0;
    end else begin
      write_index    <= write_index_next;
      active_buffer  <= active_buffer_next;
      skipping_batch <= skipping_batch_next;
      busy           <= busy_next;
      pend           <= pend_next;
    end
  end

  mcpp_fifo #(
    .WIDTH($bits(mcpp_pkg::out_word_t)),
    .DEPTH(mcpp_pkg::QUEUE_DEPTH)
  ) u_out_q (
    .clk    (clk),
    .rst    (rst),
    .push   (emit),
    .wr_data(emit_word),
    .full   (out_full),
    .pop    (pop),
    .rd_data(rd_bits),
    .empty  (empty)
  );

  assign out_word = rd_bits;

endmodule
`default_nettype wire

// ===== hdl/masked_channel_pingpong_packer_top.sv =====
// frames queue two deep ahead of the back end; its writes queue in the output queue
// throughput: one buffer write per cycle, set by the channel sequencer in the back end
// while the output queue has room; a frame is popped with its final write, if any
// reset: synchronous, active high; clears both queues, index, buffer and skip flag
// reset also loads mask 255, record length 1024 and reset mode
`default_nettype none
module masked_channel_pingpong_packer_top #(
  parameter int CHANNELS = mcpp_pkg::DEF_CHANNELS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  push,
  output logic                                       full,
  input  wire mcpp_pkg::in_word_t                    in_word,
  output logic                                       empty,
  input  wire logic                                  pop,
  output mcpp_pkg::out_word_t                        out_word,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [mcpp_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [mcpp_pkg::CFG_DATA_W-1:0]       cfg_data
);

  mcpp_pkg::cfg_t   cfg;
  mcpp_pkg::frame_t frame;
  logic             frame_empty;
  logic             frame_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mask   <= mcpp_pkg::RST_MASK;
      cfg.length <= mcpp_pkg::RST_LENGTH;
      cfg.mode   <= mcpp_pkg::RST_MODE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mcpp_pkg::CFG_MASK:   cfg.mask   <= cfg_data[7:0];
        mcpp_pkg::CFG_LENGTH: cfg.length <= cfg_data[15:0];
        mcpp_pkg::CFG_MODE:   cfg.mode   <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  mcpp_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .in_word    (in_word),
    .full       (full),
    .mask       (cfg.mask),
    .frame_pop  (frame_pop),
    .frame      (frame),
    .frame_empty(frame_empty)
  );

  mcpp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .frame      (frame),
    .frame_empty(frame_empty),
    .frame_pop  (frame_pop),
    .empty      (empty),
    .pop        (pop),
    .out_word   (out_word)
  );

endmodule
`default_nettype wire

// ===== hdl/mcpp_checker.sv =====
`default_nettype none
module mcpp_checker (
  input wire logic                                  clk,
  input wire logic                                  rst,
  input wire logic                                  full,
  input wire logic                                  empty,
  input wire logic                                  pop,
  input wire mcpp_pkg::out_word_t                   out_word
);

  // both queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_word)))
    else $error("waiting word changed");

  a_full_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_word.buffer_full) |-> out_word.last)
    else $error("buffer fill not marked last");

  // words of one frame go to consecutive addresses of one buffer
  a_frame_run: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !out_word.last) ##1 !empty |->
      (out_word.write_address == $past(out_word.write_address) + 16'd1) &&
      (out_word.buffer_select == $past(out_word.buffer_select)))
    else $error("frame words not consecutive");

endmodule

bind masked_channel_pingpong_packer_top mcpp_checker u_checker (.*);
`default_nettype wire

// ===== tb/tb_masked_channel_pingpong_packer_top.sv =====
`timescale 1ns / 100ps
module tb_masked_channel_pingpong_packer_top;

  localparam int NCH = mcpp_pkg::DEF_CHANNELS;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  mcpp_pkg::in_word_t in_word = '0;
  logic empty;
  logic pop = 1'b0;
  mcpp_pkg::out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [mcpp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [mcpp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  masked_channel_pingpong_packer_top #(.CHANNELS(NCH)) dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .in_word(in_word),
    .empty(empty),
    .pop(pop),
    .out_word(out_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of registers and packer state
  logic [7:0] cur_mask = mcpp_pkg::RST_MASK;
  logic [15:0] cur_len = mcpp_pkg::RST_LENGTH;
  logic [1:0] cur_mode = mcpp_pkg::RST_MODE;
  logic [15:0] wr_idx = '0;
  logic act_buf = 1'b0;
  logic skipping = 1'b0;

  mcpp_pkg::in_word_t frames_to_send[$];
  mcpp_pkg::out_word_t expected_writes[$];
  int frames_queued = 0;
  int frames_driven = 0;
  int frames_taken = 0;
  int errors = 0;
  int send_idle_pct = 0;
  int pop_stall_pct = 0;

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  task automatic pack_frame(mcpp_pkg::in_word_t w);
    logic [15:0] smp [0:7];
    mcpp_pkg::out_word_t res [0:7];
    int n;
    n = 0;
    smp[0] = w.sample_0;
    smp[1] = w.sample_1;
    smp[2] = w.sample_2;
    smp[3] = w.sample_3;
    smp[4] = w.sample_4;
    smp[5] = w.sample_5;
    smp[6] = w.sample_6;
    smp[7] = w.sample_7;
    if (cur_mode == mcpp_pkg::MODE_HOLD) begin
      if (w.batch_end) skipping = 1'b0;
      return;
    end
    if (cur_mode != mcpp_pkg::MODE_RECORD) begin
      wr_idx = '0;
      act_buf = 1'b0;
      skipping = 1'b0;
      return;
    end
    if (skipping) begin
      if (w.batch_end) skipping = 1'b0;
      return;
    end
    for (int ch = 0; ch < NCH; ch++) begin
      if (!cur_mask[ch]) continue;
      if (cur_len == 16'd0 || wr_idx > cur_len - 16'd1) continue;
      res[n].buffer_select = act_buf;
      res[n].write_address = wr_idx;
      res[n].sample_value = {smp[ch][7:0], smp[ch][15:8]};
      res[n].last = 1'b0;
      if (wr_idx == cur_len - 16'd1) begin
        res[n].buffer_full = 1'b1;
        n++;
        wr_idx = '0;
        act_buf = ~act_buf;
        skipping = ~w.batch_end;
        break;
      end
      res[n].buffer_full = 1'b0;
      n++;
      wr_idx = wr_idx + 16'd1;
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) expected_writes.push_back(res[k]);
  endtask

  task automatic check_write(mcpp_pkg::out_word_t got);
    mcpp_pkg::out_word_t exp_w;
    if (expected_writes.size() == 0) begin
      report_mismatch($sformatf("word %h with nothing expected", got));
      return;
    end
    exp_w = expected_writes.pop_front();
    if (got.buffer_select !== exp_w.buffer_select)
      report_mismatch($sformatf("buffer_select %b, expected %b",
                                got.buffer_select, exp_w.buffer_select));
    if (got.write_address !== exp_w.write_address)
      report_mismatch($sformatf("write_address %0d, expected %0d",
                                got.write_address, exp_w.write_address));
    if (got.sample_value !== exp_w.sample_value)
      report_mismatch($sformatf("sample_value %h, expected %h",
                                got.sample_value, exp_w.sample_value));
    if (got.buffer_full !== exp_w.buffer_full)
      report_mismatch($sformatf("buffer_full %b, expected %b",
                                got.buffer_full, exp_w.buffer_full));
    if (got.last !== exp_w.last)
      report_mismatch($sformatf("last %b, expected %b", got.last, exp_w.last));
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
      pop <= 1'b0;
    end else begin
      if (frames_driven == frames_taken) begin
        if (frames_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_word <= frames_to_send.pop_front();
          push <= 1'b1;
          frames_driven++;
        end else begin
          push <= 1'b0;
        end
      end
      pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        pack_frame(in_word);
        frames_taken++;
      end
      if (pop && !empty) check_write(out_word);
    end
  end

  function automatic mcpp_pkg::in_word_t make_frame(logic [15:0] base, logic be);
    mcpp_pkg::in_word_t w;
    w.sample_0 = base;
    w.sample_1 = base + 16'd1;
    w.sample_2 = base + 16'd2;
    w.sample_3 = base + 16'd3;
    w.sample_4 = base + 16'd4;
    w.sample_5 = base + 16'd5;
    w.sample_6 = base + 16'd6;
    w.sample_7 = base + 16'd7;
    w.batch_end = be;
    return w;
  endfunction

  function automatic mcpp_pkg::in_word_t rand_frame(logic be);
    mcpp_pkg::in_word_t w;
    w.sample_0 = 16'($urandom_range(65535));
    w.sample_1 = 16'($urandom_range(65535));
    w.sample_2 = 16'($urandom_range(65535));
    w.sample_3 = 16'($urandom_range(65535));
    w.sample_4 = 16'($urandom_range(65535));
    w.sample_5 = 16'($urandom_range(65535));
    w.sample_6 = 16'($urandom_range(65535));
    w.sample_7 = 16'($urandom_range(65535));
    w.batch_end = be;
    return w;
  endfunction

  task automatic queue_frame(mcpp_pkg::in_word_t w);
    frames_to_send.push_back(w);
    frames_queued++;
  endtask

  // well-formed batches with a little noise on batch_end
  task automatic queue_batches(int count);
    int left;
    int blen;
    logic be;
    left = count;
    while (left > 0) begin
      blen = $urandom_range(6, 1);
      for (int i = 0; i < blen && left > 0; i++) begin
        be = (i == blen - 1);
        if ($urandom_range(9) == 0) be = 1'($urandom_range(1));
        queue_frame(rand_frame(be));
        left--;
      end
    end
  endtask

  task automatic wait_results;
    while (frames_taken != frames_queued || expected_writes.size() != 0) @(negedge clk);
  endtask

  task automatic drain;
    wait_results();
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [mcpp_pkg::CFG_INDEX_W-1:0] idx,
                           logic [mcpp_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      mcpp_pkg::CFG_MASK: cur_mask = data[7:0];
      mcpp_pkg::CFG_LENGTH: cur_len = data;
      mcpp_pkg::CFG_MODE: cur_mode = data[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] mask;
    logic [15:0] len;
    logic [1:0] mode;
    logic [15:0] word;
    int n;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset mode after reset emits nothing
    queue_frame(make_frame(16'h1234, 1'b1));
    drain();
    write_reg(mcpp_pkg::CFG_LENGTH, 16'd5);
    write_reg(mcpp_pkg::CFG_MODE, mcpp_pkg::MODE_RECORD);
    // fill, skip rest of batch, fill on batch end, fill again
    queue_frame(make_frame(16'h0000, 1'b0));
    queue_frame(make_frame(16'hFFF8, 1'b0));
    queue_frame(make_frame(16'h00FF, 1'b1));
    queue_frame(make_frame(16'hFFF8, 1'b1));
    queue_frame(make_frame(16'h7F80, 1'b0));
    drain();
    // hold mode clears the skip on batch end
    write_reg(mcpp_pkg::CFG_MODE, mcpp_pkg::MODE_HOLD);
    queue_frame(make_frame(16'h1111, 1'b1));
    drain();
    write_reg(mcpp_pkg::CFG_MODE, mcpp_pkg::MODE_RECORD);
    queue_frame(make_frame(16'h2222, 1'b0));
    drain();
    write_reg(mcpp_pkg::CFG_MASK, 16'h0000);
    queue_frame(make_frame(16'h3333, 1'b1));
    drain();
    write_reg(mcpp_pkg::CFG_MASK, 16'hFFA5);
    write_reg(mcpp_pkg::CFG_LENGTH, 16'd0);
    queue_frame(make_frame(16'h4444, 1'b1));
    drain();
    // index above a shortened length
    write_reg(mcpp_pkg::CFG_MASK, 16'h00FF);
    write_reg(mcpp_pkg::CFG_LENGTH, 16'd20);
    queue_frame(make_frame(16'h5555, 1'b1));
    queue_frame(make_frame(16'h5A5A, 1'b1));
    drain();
    write_reg(mcpp_pkg::CFG_LENGTH, 16'd5);
    queue_frame(make_frame(16'h6666, 1'b1));
    drain();
    // mode three behaves as reset
    write_reg(mcpp_pkg::CFG_MODE, 16'hFFFF);
    queue_frame(make_frame(16'h7777, 1'b1));
    drain();
    write_reg(mcpp_pkg::CFG_MODE, mcpp_pkg::MODE_RECORD);
    write_reg(mcpp_pkg::CFG_LENGTH, 16'd1);
    queue_frame(make_frame(16'h8888, 1'b0));
    queue_frame(make_frame(16'h9999, 1'b1));
    drain();
    write_reg(mcpp_pkg::CFG_SPARE, 16'hFFFF);
    write_reg(mcpp_pkg::CFG_LENGTH, 16'hFFFF);
    queue_frame(make_frame(16'hAAAA, 1'b1));
    queue_frame(make_frame(16'hCCCC, 1'b0));

    for (int p = 0; p < 12; p++) begin
      mask = 8'($urandom_range(255));
      if ($urandom_range(3) == 0) len = 16'($urandom_range(300, 25));
      else len = 16'($urandom_range(24, 2));
      mode = mcpp_pkg::MODE_RECORD;
      if (p == 0) begin
        mask = 8'hFF;
        len = 16'd1;
      end
      if (p == 1) len = 16'hFFFF;
      if (p == 6) mode = mcpp_pkg::MODE_HOLD;
      if (p == 9) mode = mcpp_pkg::MODE_SPARE;
      n = (mode == mcpp_pkg::MODE_RECORD) ? 40 : 10;
      drain();
      word = 16'($urandom_range(65535));
      word[7:0] = mask;
      write_reg(mcpp_pkg::CFG_MASK, word);
      write_reg(mcpp_pkg::CFG_LENGTH, len);
      word = 16'($urandom_range(65535));
      word[1:0] = mode;
      write_reg(mcpp_pkg::CFG_MODE, word);
      case (p % 4)
        0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_idle_pct = 49; pop_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  pop_stall_pct = 49; end
        default: begin send_idle_pct = 11; pop_stall_pct = 11; end
      endcase
      queue_batches(n / 2);
      // sender holds back until every pending write has come out
      wait_results();
      queue_batches(n - n / 2);
    end

    drain();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule
